>>> rtl/swrm_pkg.sv
//------------------------------------------------------------------------------
// swrm_pkg
// Shared types and constants of the sliding window rate meter.
//------------------------------------------------------------------------------
package swrm_pkg;

    localparam int unsigned MsPerSecond = 1000;
    localparam int unsigned WinRegWidth = 7;
    localparam logic [31:0] Sat32 = 32'hFFFF_FFFF;

    // stall spans at or above this many ms give more than 32 bits of seconds
    localparam logic [63:0] StallSatMs = 64'd4294967296000;
    // ceil(2^46 / 125): floor(x / 1000) = ((x >> 3) * MsRecip) >> 46 for x < 2^42
    localparam logic [39:0] MsRecip = 40'h83_126E_978E;

    // window register reset values, by index
    function automatic logic [WinRegWidth-1:0] win_reset(input int unsigned idx);
        logic [WinRegWidth-1:0] val;
        case (idx)
            0: val = 7'd1;
            1: val = 7'd5;
            2: val = 7'd20;
            3: val = 7'd60;
            default: val = 7'd1;
        endcase
        return val;
    endfunction

    // request to the divider
    typedef struct packed {
        logic        start;
        logic [73:0] dividend;
        logic [63:0] divisor;
        logic        sat32;   // saturate quotient to 32 bits
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

>>> rtl/swrm_mul1000.sv
//------------------------------------------------------------------------------
// swrm_mul1000
// Registered multiply of a 64-bit difference by 1000, split in two halves.
//------------------------------------------------------------------------------
module swrm_mul1000 (
    input  logic        aclk,
    input  logic [63:0] diff,
    output logic [73:0] product
);
    import swrm_pkg::*;

    logic [41:0] lo_reg;
    logic [41:0] hi_reg;
    logic [41:0] lo_next;
    logic [41:0] hi_next;

    always_comb begin
        lo_next = {10'd0, diff[31:0]} * 42'(MsPerSecond);
        hi_next = {10'd0, diff[63:32]} * 42'(MsPerSecond);
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign product = {32'd0, lo_reg} + {hi_reg, 32'd0};
endmodule

>>> rtl/swrm_divider.sv
//------------------------------------------------------------------------------
// swrm_divider
// Restoring divider, one quotient bit per cycle over a 74-bit dividend.
//------------------------------------------------------------------------------
module swrm_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  swrm_pkg::div_req_t  req,
    output swrm_pkg::div_rsp_t  rsp
);
    import swrm_pkg::*;

    logic [73:0] num_reg;
    logic [64:0] rem_reg;
    logic [63:0] den_reg;
    logic [73:0] quo_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        sat_reg;
    logic [64:0] shifted;
    logic        take;

    always_comb begin
        shifted = {rem_reg[63:0], num_reg[73]};
        take    = shifted >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd74;
                num_reg  <= req.dividend;
                den_reg  <= req.divisor;
                sat_reg  <= req.sat32;
                rem_reg  <= '0;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= take ? shifted - {1'b0, den_reg} : shifted;
                quo_reg <= {quo_reg[72:0], take};
                num_reg <= {num_reg[72:0], 1'b0};
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = (sat_reg && (quo_reg[73:32] != '0)) ? Sat32 : quo_reg[31:0];
endmodule

>>> rtl/swrm_history_mem.sv
//------------------------------------------------------------------------------
// swrm_history_mem
// History ring store: time and byte total per record, registered read.
//------------------------------------------------------------------------------
module swrm_history_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [127:0]  wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [127:0]  rd_data
);
    logic [127:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

>>> rtl/sliding_window_rate_meter_core.sv
// Sequence: a plain word only updates the running total; a tick word gives its result
//   after ST_CHK_STALL, the read, multiply and one-bit-per-cycle division of each window,
//   the stall seconds and ST_OUT (a window with equal timestamps skips the division).
// Throughput: one plain word per cycle; ticks hold the input until the result is out.
// Reset: aresetn synchronous, active low; afterwards a clearing pass writes
//   HISTORY_DEPTH history rows, one per cycle, while no word is taken.
//------------------------------------------------------------------------------
// sliding_window_rate_meter_core
// Multi-window throughput meter around a history ring memory.
//------------------------------------------------------------------------------
module sliding_window_rate_meter_core #(
    parameter int unsigned HISTORY_DEPTH = 64,
    parameter int unsigned WINDOW_COUNT  = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [95:0]           s_tdata,   // byte_count[31:0], now_ms[95:32]
    input  logic                  s_tuser,   // tick_due
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [32*(2*WINDOW_COUNT+1)+63:0] m_tdata, // speeds, peaks, stall_seconds, total
    input  logic                  cfg_we,
    input  logic [$clog2(WINDOW_COUNT+1)-1:0] cfg_index,
    input  logic [6:0]            cfg_data
);
    import swrm_pkg::*;

    localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned WW = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1;
    localparam int unsigned OW = 32 * (2 * WINDOW_COUNT + 1) + 64;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD_NEWEST, ST_CHK_STALL, ST_RD_WIN, ST_WIN_DATA,
        ST_MUL, ST_DIV_START, ST_DIV_WAIT, ST_STALL_MUL, ST_STALL_START,
        ST_STALL_WAIT, ST_OUT
    } state_t;

    state_t state_reg;
    logic [AW:0]   clr_cnt_reg;
    logic [AW-1:0] head_reg;
    logic [63:0]   total_reg;
    logic [63:0]   stall_start_reg;
    logic [63:0]   now_reg;
    logic [WW-1:0] win_reg;
    logic [63:0]   rec_time_reg;
    logic [63:0]   diff_reg;
    logic [31:0]   stall_sec_reg;
    logic [58:0]   stall_lo_reg;
    logic [58:0]   stall_hi_reg;
    logic          stall_sat_reg;
    logic [6:0]    win_ticks_reg [WINDOW_COUNT];
    logic [31:0]   speed_reg [WINDOW_COUNT];
    logic [31:0]   peak_reg [WINDOW_COUNT];
    logic          m_tvalid_reg;
    logic [OW-1:0] m_tdata_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [127:0]  mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [127:0]  mem_rdata;
    logic [63:0]   total_next;
    logic [AW-1:0] back_idx;
    logic [6:0]    w_eff;
    logic [73:0]   product;
    div_req_t      div_req;
    div_rsp_t      div_rsp;
    logic          accept;
    logic [OW-1:0] out_word;
    logic [38:0]   stall_ms8;
    logic [58:0]   stall_lo_next;
    logic [58:0]   stall_hi_next;
    logic [78:0]   stall_prod;
    logic [31:0]   stall_quo;

    swrm_history_mem #(.DEPTH(HISTORY_DEPTH), .AW(AW)) u_mem (
        .aclk(aclk), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(mem_wdata),
        .rd_addr(mem_raddr), .rd_data(mem_rdata)
    );

    swrm_mul1000 u_mul (.aclk(aclk), .diff(diff_reg), .product(product));

    swrm_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign total_next = total_reg + {32'd0, s_tdata[31:0]};

    // clamp window length to 1..HISTORY_DEPTH and step back that far from head
    always_comb begin
        w_eff = win_ticks_reg[win_reg];
        if (w_eff == 7'd0) begin
            w_eff = 7'd1;
        end
        if ({25'd0, w_eff} > 32'(HISTORY_DEPTH)) begin
            w_eff = 7'(HISTORY_DEPTH);
        end
        if (32'(head_reg) >= 32'(w_eff)) begin
            back_idx = AW'(32'(head_reg) - 32'(w_eff));
        end else begin
            back_idx = AW'(32'(head_reg) + 32'(HISTORY_DEPTH) - 32'(w_eff));
        end
    end

    // seconds from ms: reciprocal multiply in two 39x20 halves, summed next cycle
    always_comb begin
        stall_ms8     = diff_reg[41:3];
        stall_lo_next = {20'd0, stall_ms8} * {39'd0, MsRecip[19:0]};
        stall_hi_next = {20'd0, stall_ms8} * {39'd0, MsRecip[39:20]};
        stall_prod    = {20'd0, stall_lo_reg} + {stall_hi_reg, 20'd0};
        stall_quo     = stall_prod[77:46];
    end

    always_comb begin
        mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_STALL_MUL);
        mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg[AW-1:0] : head_reg;
        mem_wdata = (state_reg == ST_CLEAR) ? 128'd0 : {now_reg, total_reg};
        mem_raddr = back_idx;
        if (state_reg == ST_IDLE) begin
            mem_raddr = (head_reg == '0) ? AW'(HISTORY_DEPTH - 1) : head_reg - AW'(1);
        end
        div_req = '0;
        if (state_reg == ST_DIV_START) begin
            div_req = '{start: 1'b1, dividend: product, divisor: now_reg - rec_time_reg,
                        sat32: 1'b1};
        end
    end

    always_comb begin
        for (int i = 0; i < WINDOW_COUNT; i++) begin
            out_word[32*i +: 32]                  = speed_reg[i];
            out_word[32*(WINDOW_COUNT+i) +: 32]   = peak_reg[i];
        end
        out_word[32*2*WINDOW_COUNT +: 32] = stall_sec_reg;
        out_word[OW-1 -: 64]              = total_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            head_reg        <= '0;
            total_reg       <= '0;
            stall_start_reg <= '0;
            m_tvalid_reg    <= 1'b0;
            win_reg         <= '0;
            for (int i = 0; i < WINDOW_COUNT; i++) begin
                win_ticks_reg[i] <= win_reset(i);
                speed_reg[i]     <= '0;
                peak_reg[i]      <= '0;
            end
        end else begin
            if (cfg_we && (32'(cfg_index) < WINDOW_COUNT)) begin
                win_ticks_reg[WW'(cfg_index)] <= cfg_data;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (32'(clr_cnt_reg) == HISTORY_DEPTH - 1) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        total_reg <= total_next;
                        now_reg   <= s_tdata[95:32];
                        if (s_tuser) begin
                            state_reg <= ST_CHK_STALL;
                        end
                    end
                end
                ST_CHK_STALL: begin
                    // newest record read issued in idle
                    if (total_reg == mem_rdata[63:0]) begin
                        if (stall_start_reg == '0) begin
                            stall_start_reg <= now_reg;
                        end
                    end else begin
                        stall_start_reg <= '0;
                    end
                    win_reg   <= '0;
                    state_reg <= ST_RD_WIN;
                end
                ST_RD_WIN: begin
                    state_reg <= ST_WIN_DATA;
                end
                ST_WIN_DATA: begin
                    rec_time_reg <= mem_rdata[127:64];
                    diff_reg     <= total_reg - mem_rdata[63:0];
                    if (now_reg == mem_rdata[127:64]) begin
                        state_reg <= ST_DIV_WAIT;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_DIV_START;
                end
                ST_DIV_START: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (!div_rsp.busy) begin
                        if (div_rsp.done) begin
                            speed_reg[win_reg] <= div_rsp.quotient;
                            if (div_rsp.quotient > peak_reg[win_reg]) begin
                                peak_reg[win_reg] <= div_rsp.quotient;
                            end
                        end
                        if (32'(win_reg) == WINDOW_COUNT - 1) begin
                            state_reg <= ST_STALL_MUL;
                        end else begin
                            win_reg   <= win_reg + 1'b1;
                            state_reg <= ST_RD_WIN;
                        end
                    end
                end
                ST_STALL_MUL: begin
                    // push the record, advance head
                    head_reg  <= (32'(head_reg) == HISTORY_DEPTH - 1) ? '0
                                                                    : head_reg + AW'(1);
                    diff_reg  <= now_reg - stall_start_reg;
                    state_reg <= ST_STALL_START;
                end
                ST_STALL_START: begin
                    stall_lo_reg  <= stall_lo_next;
                    stall_hi_reg  <= stall_hi_next;
                    stall_sat_reg <= (diff_reg >= StallSatMs);
                    state_reg     <= ST_STALL_WAIT;
                end
                ST_STALL_WAIT: begin
                    if (stall_start_reg == '0) begin
                        stall_sec_reg <= 32'd0;
                    end else begin
                        stall_sec_reg <= stall_sat_reg ? Sat32 : stall_quo;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= out_word;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (m_tvalid_reg && m_tready && !(state_reg == ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.busy |-> !s_tready) else $error("input taken during division");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");
    a_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready) else $error("input taken during clear");
endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// testbench
// Drives byte-count words and tick words into the rate meter, predicts every
// tick result in a behavioral model of its own and checks each result word
// field by field. The test covers the window registers, the stall detection,
// speed saturation and a stretch of receiver backpressure.
//------------------------------------------------------------------------------
module testbench;
    import swrm_pkg::*;

    localparam int unsigned Depth      = 64;
    localparam int unsigned Windows    = 4;
    localparam int unsigned IdxWidth   = $clog2(Windows + 1);
    localparam int unsigned TickCycles = Windows * 78 + 80;
    localparam int unsigned IdleLimit  = 8000;

    typedef enum logic [IdxWidth-1:0] {
        WIN_A    = 0,
        WIN_B    = 1,
        WIN_C    = 2,
        WIN_D    = 3,
        WIN_NONE = 4
    } win_reg_e;

    // same layout as m_tdata: speeds in the lowest bits, total on top
    typedef struct packed {
        logic [63:0]        total;
        logic [31:0]        stall_sec;
        logic [3:0][31:0]   peak;
        logic [3:0][31:0]   speed;
    } meter_word_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [95:0]            s_tdata = '0;   // byte_count[31:0], now_ms[95:32]
    logic                   s_tuser = 1'b0; // tick_due
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [351:0]           m_tdata;        // speed a..d, peak a..d, stall_seconds, total
    logic                   cfg_we = 1'b0;
    logic [IdxWidth-1:0]    cfg_index = '0;
    logic [6:0]             cfg_data = '0;

    // meter model state
    logic [6:0]             win_ticks [Windows];
    logic [63:0]            byte_sum;
    logic [63:0]            stall_from_ms;
    logic [63:0]            ring_ms [Depth];
    logic [63:0]            ring_bytes [Depth];
    logic [5:0]             ring_head;
    logic [31:0]            speed_now [Windows];
    logic [31:0]            speed_peak [Windows];

    meter_word_t            pending_words [$];
    int unsigned            mismatches = 0;
    logic                   src_gaps = 1'b0;
    logic                   sink_gaps = 1'b0;
    logic                   sink_hold = 1'b0;
    int unsigned            sink_gap_left = 0;
    int unsigned            quiet_cycles = 0;
    logic [63:0]            clock_ms = 64'd0;

    sliding_window_rate_meter_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic logic [31:0] bytes_per_sec(input logic [63:0] bytes,
                                                  input logic [63:0] ms);
        logic [127:0] quo;
        quo = ({64'd0, bytes} * 128'(MsPerSecond)) / {64'd0, ms};
        return (quo > 128'(Sat32)) ? Sat32 : quo[31:0];
    endfunction

    task automatic meter_clear();
        for (int i = 0; i < Windows; i++) begin
            speed_now[i]  = '0;
            speed_peak[i] = '0;
        end
        win_ticks[0] = 7'd1;
        win_ticks[1] = 7'd5;
        win_ticks[2] = 7'd20;
        win_ticks[3] = 7'd60;
        for (int i = 0; i < Depth; i++) begin
            ring_ms[i]    = '0;
            ring_bytes[i] = '0;
        end
        byte_sum      = '0;
        stall_from_ms = '0;
        ring_head     = '0;
    endtask

    // advance the meter model by one accepted word
    task automatic meter_update(input logic [31:0] bc, input logic tick,
                                input logic [63:0] ms);
        logic [5:0]   idx;
        logic [6:0]   win;
        logic [63:0]  secs;
        meter_word_t  w;
        byte_sum += {32'd0, bc};
        if (!tick)
            return;
        idx = ring_head - 6'd1;
        if (byte_sum == ring_bytes[idx]) begin
            if (stall_from_ms == 0)
                stall_from_ms = ms;
        end else begin
            stall_from_ms = '0;
        end
        for (int i = 0; i < Windows; i++) begin
            win = win_ticks[i];
            if (win < 1)
                win = 7'd1;
            if (win > Depth)
                win = 7'(Depth);
            idx = ring_head - win[5:0];
            if (ms != ring_ms[idx]) begin
                speed_now[i] = bytes_per_sec(byte_sum - ring_bytes[idx], ms - ring_ms[idx]);
                if (speed_now[i] > speed_peak[i])
                    speed_peak[i] = speed_now[i];
            end
        end
        ring_ms[ring_head]    = ms;
        ring_bytes[ring_head] = byte_sum;
        ring_head++;
        secs = (stall_from_ms == 0) ? 64'd0 : (ms - stall_from_ms) / MsPerSecond;
        w.stall_sec = (secs > 64'(Sat32)) ? Sat32 : secs[31:0];
        w.total = byte_sum;
        for (int i = 0; i < Windows; i++) begin
            w.speed[i] = speed_now[i];
            w.peak[i]  = speed_peak[i];
        end
        pending_words.push_back(w);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_word(input logic [31:0] bc, input logic tick, input logic [63:0] ms);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ms, bc};
        s_tuser  <= tick;
        do @(posedge aclk); while (!s_tready);
        meter_update(bc, tick, ms);
    endtask

    // stop offering and wait until every tick result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_words.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_window(input win_reg_e idx, input logic [6:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx < Windows)
            win_ticks[idx] = val;
        @(posedge aclk);
    endtask

    task automatic set_windows(input logic [6:0] a, input logic [6:0] b,
                               input logic [6:0] c, input logic [6:0] d);
        wait_drained();
        repeat (10) @(posedge aclk);
        write_window(WIN_A, a);
        write_window(WIN_B, b);
        write_window(WIN_C, c);
        write_window(WIN_D, d);
    endtask

    task automatic send_random_word(input int tick_odds);
        logic [31:0] bc;
        logic        tick;
        tick = ($urandom_range(0, tick_odds - 1) == 0);
        case ($urandom_range(0, 7))
            0, 1:    bc = 32'd0;
            2:       bc = 32'hFFFF_FFFF;
            default: bc = $urandom;
        endcase
        if (tick) begin
            case ($urandom_range(0, 15))
                0:       ;                                  // equal timestamps
                1:       clock_ms = {$urandom, $urandom};
                2:       clock_ms += 64'($urandom);
                default: clock_ms += 64'($urandom_range(1, 3000));
            endcase
        end
        send_word(bc, tick, tick ? clock_ms : {$urandom, $urandom});
    endtask

    task automatic test_directed();
        send_word(32'd0, 1'b1, 64'd0);              // stall seen at time zero
        send_word(32'd0, 1'b1, 64'd5);              // stall starts
        send_word(32'd0, 1'b1, 64'h8000_0000_0000_0000); // huge stall, saturates
        send_word(32'hFFFF_FFFF, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(32'hFFFF_FFFF, 1'b1, 64'h8000_0000_0000_0001); // speed saturates
        send_word(32'd100, 1'b1, 64'h8000_0000_0000_0001); // equal timestamps
        send_word(32'd1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(32'd1, 1'b1, 64'd0);              // time runs backward
        send_word(32'h5555_5555, 1'b0, 64'h5555_5555_5555_5555);
        send_word(32'hAAAA_AAAA, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(32'd1000, 1'b1, 64'd1000);
        send_word(32'd0, 1'b1, 64'd1000);
        clock_ms = 64'd1000;
    endtask

    task automatic test_window_extremes();
        set_windows(7'd0, 7'd64, 7'd127, 7'd100);
        write_window(WIN_NONE, 7'd3);
        for (int i = 0; i < 10; i++)
            send_random_word(2);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_windows(7'd1, 7'd2, 7'd3, 7'd64);
                1: set_windows(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
                               7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
                2: set_windows(7'd64, 7'd63, 7'd1, 7'd32);
                default: set_windows(7'd1, 7'd5, 7'd20, 7'd60);
            endcase
            for (int i = 0; i < 200; i++)
                send_random_word(6);
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                sink_hold <= 1'b1;
                repeat (900) @(posedge aclk);
                sink_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 40; i++)
            send_random_word(3);
        wait_drained();
    endtask

    task automatic test_full_rate();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        for (int i = 0; i < 150; i++)
            send_random_word(6);
    endtask

    // result checker
    always @(posedge aclk) begin
        meter_word_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected result", got.total, 64'd0);
            end else begin
                want = pending_words.pop_front();
                for (int i = 0; i < Windows; i++) begin
                    if (got.speed[i] !== want.speed[i])
                        report_mismatch($sformatf("speed %0d", i), got.speed[i], want.speed[i]);
                    if (got.peak[i] !== want.peak[i])
                        report_mismatch($sformatf("peak %0d", i), got.peak[i], want.peak[i]);
                end
                if (got.stall_sec !== want.stall_sec)
                    report_mismatch("stall_seconds", got.stall_sec, want.stall_sec);
                if (got.total !== want.total)
                    report_mismatch("running_total", got.total, want.total);
            end
        end
    end

    // receiver: random stall bursts plus the long hold-off
    always @(posedge aclk) begin
        if (sink_hold) begin
            m_tready <= 1'b0;
        end else if (sink_gap_left > 0) begin
            m_tready <= 1'b0;
            sink_gap_left <= sink_gap_left - 1;
        end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            sink_gap_left <= $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any accepted input word or result
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IdleLimit) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        meter_clear();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        test_directed();
        test_window_extremes();
        test_random_phases();
        test_backpressure();
        test_full_rate();
        wait_drained();
        repeat (TickCycles) @(posedge aclk);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sliding_window_rate_meter_core.f
rtl/swrm_pkg.sv
rtl/swrm_mul1000.sv
rtl/swrm_divider.sv
rtl/swrm_history_mem.sv
rtl/sliding_window_rate_meter_core.sv
bench/testbench.sv
